FILE: sv/mhcd_pkg.sv
package mhcd_pkg;

    localparam int unsigned CFG_W     = 7;
    localparam int unsigned CFG_IDX_W = 3;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHIFT_CC    = 3'd0,
        CFG_KNOB8_NOTE  = 3'd1,
        CFG_KNOB1_NOTE  = 3'd2,
        CFG_VOLUME_NOTE = 3'd3,
        CFG_WHEEL_NOTE  = 3'd4,
        CFG_PRESSED_VAL = 3'd5
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RST_SHIFT_CC    = 7'd49;
    localparam logic [CFG_W-1:0] RST_KNOB8_NOTE  = 7'd7;
    localparam logic [CFG_W-1:0] RST_KNOB1_NOTE  = 7'd0;
    localparam logic [CFG_W-1:0] RST_VOLUME_NOTE = 7'd8;
    localparam logic [CFG_W-1:0] RST_WHEEL_NOTE  = 7'd9;
    localparam logic [CFG_W-1:0] RST_PRESSED_VAL = 7'd127;

    // MIDI / USB-MIDI codes
    localparam logic [7:0] STATUS_CONTROL = 8'hB0;
    localparam logic [7:0] STATUS_NOTE_ON = 8'h90;
    localparam logic [3:0] CABLE_LAST     = 4'hF;
    localparam logic [3:0] CIN_MISC       = 4'h1;
    localparam logic [3:0] CIN_CABLE_EVT  = 4'h2;
    localparam logic [3:0] CIN_CONTROL    = 4'hB;

    typedef struct packed {
        logic [CFG_W-1:0] shift_controller;
        logic [CFG_W-1:0] knob8_note;
        logic [CFG_W-1:0] knob1_note;
        logic [CFG_W-1:0] volume_note;
        logic [CFG_W-1:0] wheel_note;
        logic [CFG_W-1:0] pressed_value;
    } cfg_t;

    typedef struct packed {
        logic [7:0] header_byte;
        logic [7:0] status_byte;
        logic [7:0] data_one;
        logic [7:0] data_two;
    } pkt_t;

    typedef struct packed {
        logic packet_ignored;
        logic shift_held;
        logic volume_touched;
        logic knob8_touched;
        logic knob1_touched;
        logic wheel_touched;
        logic launch_pulse;
        logic view_mode;
        logic mode_toggled;
    } res_t;

endpackage

FILE: sv/mhcd_pkt_if.sv
interface mhcd_pkt_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;

    modport source (
        output valid, header_byte, status_byte, data_one, data_two,
        input  ready
    );
    modport sink (
        input  valid, header_byte, status_byte, data_one, data_two,
        output ready
    );
endinterface

FILE: sv/mhcd_res_if.sv
interface mhcd_res_if;
    logic valid;
    logic ready;
    logic packet_ignored;
    logic shift_held;
    logic volume_touched;
    logic knob8_touched;
    logic knob1_touched;
    logic wheel_touched;
    logic launch_pulse;
    logic view_mode;
    logic mode_toggled;

    modport source (
        output valid, packet_ignored, shift_held, volume_touched, knob8_touched,
               knob1_touched, wheel_touched, launch_pulse, view_mode, mode_toggled,
        input  ready
    );
    modport sink (
        input  valid, packet_ignored, shift_held, volume_touched, knob8_touched,
               knob1_touched, wheel_touched, launch_pulse, view_mode, mode_toggled,
        output ready
    );
endinterface

FILE: sv/mhcd_cfg_regs.sv
module mhcd_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mhcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mhcd_pkg::CFG_W-1:0]       cfg_data,
    output mhcd_pkg::cfg_t                   cfg
);

    mhcd_pkg::cfg_t cfg_reg;
    mhcd_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (mhcd_pkg::cfg_idx_t'(cfg_index))
                mhcd_pkg::CFG_SHIFT_CC:    cfg_next.shift_controller = cfg_data;
                mhcd_pkg::CFG_KNOB8_NOTE:  cfg_next.knob8_note       = cfg_data;
                mhcd_pkg::CFG_KNOB1_NOTE:  cfg_next.knob1_note       = cfg_data;
                mhcd_pkg::CFG_VOLUME_NOTE: cfg_next.volume_note      = cfg_data;
                mhcd_pkg::CFG_WHEEL_NOTE:  cfg_next.wheel_note       = cfg_data;
                mhcd_pkg::CFG_PRESSED_VAL: cfg_next.pressed_value    = cfg_data;
                default:                   cfg_next = cfg_reg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shift_controller <= mhcd_pkg::RST_SHIFT_CC;
            cfg_reg.knob8_note       <= mhcd_pkg::RST_KNOB8_NOTE;
            cfg_reg.knob1_note       <= mhcd_pkg::RST_KNOB1_NOTE;
            cfg_reg.volume_note      <= mhcd_pkg::RST_VOLUME_NOTE;
            cfg_reg.wheel_note       <= mhcd_pkg::RST_WHEEL_NOTE;
            cfg_reg.pressed_value    <= mhcd_pkg::RST_PRESSED_VAL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: sv/mhcd_core.sv
module mhcd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,     // packet in the input stage moves on this edge
    input  mhcd_pkg::pkt_t  pkt,
    input  mhcd_pkg::cfg_t  cfg,
    output mhcd_pkg::res_t  res
);

    logic shift_reg,  shift_next;
    logic volume_reg, volume_next;
    logic knob8_reg,  knob8_next;
    logic knob1_reg,  knob1_next;
    logic wheel_reg,  wheel_next;
    logic launched_reg, launched_next;
    logic lock_reg,   lock_next;
    logic mode_reg,   mode_next;

    logic [3:0] cable;
    logic [3:0] cin;
    logic       dropped;
    logic       pressed;
    logic       is_cc;
    logic       is_note;
    logic       launch_combo;
    logic       toggle_combo;
    logic       pulse;
    logic       toggled;

    assign cable = pkt.header_byte[7:4];
    assign cin   = pkt.header_byte[3:0];

    always_comb
    begin
        dropped = (pkt.header_byte == 8'h00)
               || (cin == mhcd_pkg::CIN_MISC) || (cin == mhcd_pkg::CIN_CABLE_EVT)
               || (cable == mhcd_pkg::CABLE_LAST && cin == mhcd_pkg::CIN_CONTROL
                   && pkt.status_byte == mhcd_pkg::STATUS_CONTROL)
               || (pkt.status_byte == 8'h00 && pkt.data_one == 8'h00
                   && pkt.data_two == 8'h00);

        // data byte with MSB set never matches a 7-bit register
        pressed = (pkt.data_two == {1'b0, cfg.pressed_value});
        is_cc   = !dropped && (pkt.status_byte == mhcd_pkg::STATUS_CONTROL);
        is_note = !dropped && (pkt.status_byte == mhcd_pkg::STATUS_NOTE_ON);

        shift_next  = (is_cc && pkt.data_one == {1'b0, cfg.shift_controller})
                      ? pressed : shift_reg;
        knob8_next  = (is_note && pkt.data_one == {1'b0, cfg.knob8_note})
                      ? pressed : knob8_reg;
        knob1_next  = (is_note && pkt.data_one == {1'b0, cfg.knob1_note})
                      ? pressed : knob1_reg;
        volume_next = (is_note && pkt.data_one == {1'b0, cfg.volume_note})
                      ? pressed : volume_reg;
        wheel_next  = (is_note && pkt.data_one == {1'b0, cfg.wheel_note})
                      ? pressed : wheel_reg;

        launch_combo = shift_next && volume_next && knob8_next;
        toggle_combo = shift_next && volume_next && knob1_next;

        pulse   = !dropped && launch_combo && !launched_reg;
        toggled = !dropped && toggle_combo && !lock_reg;

        launched_next = launched_reg || pulse;
        mode_next     = mode_reg ^ toggled;
        // lock stays set exactly while the toggle combo is held
        lock_next     = dropped ? lock_reg : toggle_combo;

        res.packet_ignored = dropped;
        res.shift_held     = shift_next;
        res.volume_touched = volume_next;
        res.knob8_touched  = knob8_next;
        res.knob1_touched  = knob1_next;
        res.wheel_touched  = wheel_next;
        res.launch_pulse   = pulse;
        res.view_mode      = mode_next;
        res.mode_toggled   = toggled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg    <= 1'b0;
            volume_reg   <= 1'b0;
            knob8_reg    <= 1'b0;
            knob1_reg    <= 1'b0;
            wheel_reg    <= 1'b0;
            launched_reg <= 1'b0;
            lock_reg     <= 1'b0;
            mode_reg     <= 1'b0;
        end
        else if (fire)
        begin
            shift_reg    <= shift_next;
            volume_reg   <= volume_next;
            knob8_reg    <= knob8_next;
            knob1_reg    <= knob1_next;
            wheel_reg    <= wheel_next;
            launched_reg <= launched_next;
            lock_reg     <= lock_next;
            mode_reg     <= mode_next;
        end
    end

    // launch fires once until reset
    assert property (@(posedge clk) disable iff (!rst_n)
        launched_reg |-> !res.launch_pulse)
        else $error("launch pulse repeated");

    // mode only changes by a reported toggle
    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != $past(mode_reg) |-> $past(fire && res.mode_toggled))
        else $error("display mode changed without toggle");

    // dropped packet leaves every flag alone
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.packet_ignored |=> $stable({shift_reg, volume_reg, knob8_reg,
                                                knob1_reg, wheel_reg, launched_reg,
                                                lock_reg, mode_reg}))
        else $error("state changed on dropped packet");

    // no toggle while the lock is held
    assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> !res.mode_toggled)
        else $error("toggle while locked");

endmodule

FILE: sv/midi_hotkey_combo_detector.sv
// USB-MIDI hotkey combo detector. Takes one four-byte event packet per
// transaction on pkt and returns exactly one result transaction on res for
// each, in order. Throughput is one packet per clock while res.ready is
// high; a packet passes the input stage, then the result register. The
// flag update for a packet is done in the cycle it leaves the input stage,
// so the next packet sees the updated state with no bubble. Configuration
// registers are written through cfg_we/cfg_index/cfg_data (index 0..5,
// others ignored) and must only be written while no packet is in flight.
module midi_hotkey_combo_detector (
    input  logic                            clk,
    input  logic                            rst_n,
    mhcd_pkt_if.sink                        pkt,
    mhcd_res_if.source                      res,
    input  logic                            cfg_we,
    input  logic [mhcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mhcd_pkg::CFG_W-1:0]      cfg_data
);

    mhcd_pkg::cfg_t cfg;
    mhcd_pkg::pkt_t pkt_reg;
    mhcd_pkg::res_t res_reg;
    mhcd_pkg::res_t res_next;
    logic           in_valid_reg;
    logic           out_valid_reg;
    logic           advance;   // input stage hands its packet to the result register
    logic           accept;

    mhcd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mhcd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .pkt   (pkt_reg),
        .cfg   (cfg),
        .res   (res_next)
    );

    // Two-stage pipe: each stage loads whenever the one downstream frees up.
    assign advance   = in_valid_reg && (!out_valid_reg || res.ready);
    assign pkt.ready = !in_valid_reg || advance;
    assign accept    = pkt.valid && pkt.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pkt.ready)
            begin
                in_valid_reg <= pkt.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pkt_reg.header_byte <= pkt.header_byte;
            pkt_reg.status_byte <= pkt.status_byte;
            pkt_reg.data_one    <= pkt.data_one;
            pkt_reg.data_two    <= pkt.data_two;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.packet_ignored = res_reg.packet_ignored;
    assign res.shift_held     = res_reg.shift_held;
    assign res.volume_touched = res_reg.volume_touched;
    assign res.knob8_touched  = res_reg.knob8_touched;
    assign res.knob1_touched  = res_reg.knob1_touched;
    assign res.wheel_touched  = res_reg.wheel_touched;
    assign res.launch_pulse   = res_reg.launch_pulse;
    assign res.view_mode      = res_reg.view_mode;
    assign res.mode_toggled   = res_reg.mode_toggled;

endmodule
